@@ rtl/mrdf_pkg.sv @@
`default_nettype none
package mrdf_pkg;

	localparam int SEEN_DEPTH = 16;
	localparam int SEEN_AW = $clog2(SEEN_DEPTH);
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IN_W = 72;
	localparam int OUT_W = 48;
	localparam int CFG_AW = 3;

	typedef enum logic [CFG_AW-1:0] {
		REG_NODE_ID,
		REG_BCAST_ID,
		REG_DEFAULT_TTL,
		REG_TYPE_PRESENCE,
		REG_TYPE_ROUTE_ADV,
		REG_TYPE_ACK,
		REG_TYPE_CHAT
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ACT_DROP,
		ACT_PRESENCE,
		ACT_ROUTE_ADV,
		ACT_ACK,
		ACT_FOR_ME,
		ACT_RELAYED,
		ACT_EXPIRED
	} action_t;

	typedef enum logic [2:0] {
		KIND_PRESENCE,
		KIND_ROUTE_ADV,
		KIND_ACK,
		KIND_CHAT,
		KIND_OTHER
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_DEC
	} back_state_t;

	typedef struct packed {
		logic [7:0] msg_type;
		logic [7:0] src_node;
		logic [7:0] msg_id;
	} seen_key_t;

	typedef struct packed {
		logic       early_drop;
		seen_key_t  key;
		kind_t      kind;
		logic       chat_code;
		logic       dst_me;
		logic       for_us;
		logic       eligible;
		logic       can_relay;
		logic       learn_nb;
		logic       learn_src;
		logic [7:0] cost;
		logic [7:0] relay_ttl;
		logic       has_payload;
		logic [7:0] first_payload;
	} desc_t;

	typedef struct packed {
		action_t    action;
		logic       send_ack;
		logic [7:0] ack_msg_id;
		logic       relay;
		logic [7:0] relay_ttl;
		logic       learn_neighbor;
		logic       learn_source;
		logic [7:0] source_cost;
		logic       deliver_chat;
		logic       update_directory;
		logic       resolve_ack;
		logic [7:0] acked_id;
	} result_t;

endpackage
`default_nettype wire

@@ rtl/mrdf_front.sv @@
`default_nettype none
module mrdf_front
	import mrdf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [7:0]        cfg_wdata,
	input  wire logic              in_valid,
	input  wire logic [IN_W-1:0]   in_data,
	output desc_t                  desc
);

	logic [7:0] node_id_q;
	logic [7:0] bcast_id_q;
	logic [7:0] default_ttl_q;
	logic [7:0] type_presence_q;
	logic [7:0] type_route_adv_q;
	logic [7:0] type_ack_q;
	logic [7:0] type_chat_q;

	logic       too_short;
	logic [7:0] msg_type;
	logic [7:0] src_node;
	logic [7:0] dst_node;
	logic [7:0] prev_hop;
	logic [7:0] next_hop;
	logic [7:0] msg_id;
	logic [7:0] ttl;
	logic       has_payload;
	logic [7:0] first_payload;
	logic       learn_nb;
	logic       learn_src;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q        <= 8'd0;
			bcast_id_q       <= 8'd255;
			default_ttl_q    <= 8'd7;
			type_presence_q  <= 8'd0;
			type_route_adv_q <= 8'd1;
			type_ack_q       <= 8'd2;
			type_chat_q      <= 8'd3;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_NODE_ID:        node_id_q <= cfg_wdata;
				REG_BCAST_ID:       bcast_id_q <= cfg_wdata;
				REG_DEFAULT_TTL:    default_ttl_q <= cfg_wdata;
				REG_TYPE_PRESENCE:  type_presence_q <= cfg_wdata;
				REG_TYPE_ROUTE_ADV: type_route_adv_q <= cfg_wdata;
				REG_TYPE_ACK:       type_ack_q <= cfg_wdata;
				REG_TYPE_CHAT:      type_chat_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign too_short     = in_data[0];
	assign msg_type      = in_data[8:1];
	assign src_node      = in_data[16:9];
	assign dst_node      = in_data[24:17];
	assign prev_hop      = in_data[32:25];
	assign next_hop      = in_data[40:33];
	assign msg_id        = in_data[48:41];
	assign ttl           = in_data[56:49];
	assign has_payload   = in_data[57];
	assign first_payload = in_data[65:58];

	assign learn_nb  = (prev_hop != node_id_q);
	assign learn_src = learn_nb && (src_node != prev_hop);

	always_comb begin
		desc = '0;
		if (in_valid) begin
			desc.early_drop    = too_short || (src_node == node_id_q);
			desc.key.msg_type  = msg_type;
			desc.key.src_node  = src_node;
			desc.key.msg_id    = msg_id;
			if (msg_type == type_presence_q) begin
				desc.kind = KIND_PRESENCE;
			end else if (msg_type == type_route_adv_q) begin
				desc.kind = KIND_ROUTE_ADV;
			end else if (msg_type == type_ack_q) begin
				desc.kind = KIND_ACK;
			end else if (msg_type == type_chat_q) begin
				desc.kind = KIND_CHAT;
			end else begin
				desc.kind = KIND_OTHER;
			end
			desc.chat_code     = (msg_type == type_chat_q);
			desc.dst_me        = (dst_node == node_id_q);
			desc.for_us        = (dst_node == node_id_q) || (dst_node == bcast_id_q);
			desc.eligible      = (next_hop == node_id_q) || (next_hop == bcast_id_q);
			desc.can_relay     = desc.eligible && (ttl > 8'd1);
			desc.learn_nb      = learn_nb;
			desc.learn_src     = learn_src;
			desc.cost          = learn_src ? (default_ttl_q - ttl + 8'd1) : 8'd0;
			desc.relay_ttl     = ttl - 8'd1;
			desc.has_payload   = has_payload;
			desc.first_payload = first_payload;
		end
	end

endmodule
`default_nettype wire

@@ rtl/mrdf_queue.sv @@
`default_nettype none
module mrdf_queue
	import mrdf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t push_data,
	output logic       full,
	input  wire logic  pop,
	output desc_t      pop_data,
	output logic       empty
);

	desc_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wr_ptr_q;
	logic [QUEUE_AW-1:0]  rd_ptr_q;
	logic [QUEUE_CW-1:0]  count_q;
	logic                 do_push;
	logic                 do_pop;

	assign full     = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/mrdf_back.sv @@
`default_nettype none
module mrdf_back
	import mrdf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_empty,
	input  wire desc_t q_data,
	output logic       q_pop,
	output logic       out_valid,
	input  wire logic  out_ready,
	output result_t    out_result
);

	back_state_t          st_q;
	back_state_t          st_d;
	desc_t                work_q;
	logic                 hit_q;
	logic                 hit;
	logic                 fire;
	logic                 out_free;
	logic                 cache_wr;
	result_t              res;
	result_t              res_q;
	logic                 out_valid_q;
	logic                 seen_valid_q [SEEN_DEPTH];
	seen_key_t            seen_key_q [SEEN_DEPTH];
	logic [SEEN_AW-1:0]   seen_ptr_q;

	always_comb begin
		hit = 1'b0;
		for (int i = 0; i < SEEN_DEPTH; i++) begin
			if (seen_valid_q[i] && (seen_key_q[i] == work_q.key)) begin
				hit = 1'b1;
			end
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign fire     = (st_q == ST_DEC) && out_free;
	assign q_pop    = !q_empty && ((st_q == ST_IDLE) || fire);
	assign cache_wr = fire && !work_q.early_drop && !hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: begin
				if (q_pop) begin
					st_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				st_d = ST_DEC;
			end
			ST_DEC: begin
				if (fire) begin
					st_d = q_pop ? ST_LOOK : ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		res = '0;
		res.action = ACT_DROP;
		if (work_q.early_drop) begin
			res.action = ACT_DROP;
		end else if (hit_q) begin
			if (work_q.chat_code && work_q.dst_me) begin
				res.send_ack   = 1'b1;
				res.ack_msg_id = work_q.key.msg_id;
			end
		end else begin
			res.learn_neighbor = work_q.learn_nb;
			res.learn_source   = work_q.learn_src;
			res.source_cost    = work_q.cost;
			case (work_q.kind)
				KIND_PRESENCE: begin
					res.update_directory = work_q.has_payload;
					res.relay            = work_q.can_relay;
					res.action           = ACT_PRESENCE;
				end
				KIND_ROUTE_ADV: begin
					res.action = ACT_ROUTE_ADV;
				end
				KIND_ACK: begin
					if (work_q.dst_me) begin
						if (work_q.has_payload) begin
							res.resolve_ack = 1'b1;
							res.acked_id    = work_q.first_payload;
						end
						res.action = ACT_ACK;
					end else if (work_q.eligible) begin
						res.relay  = work_q.can_relay;
						res.action = work_q.can_relay ? ACT_ACK : ACT_EXPIRED;
					end else begin
						res.action = ACT_ACK;
					end
				end
				KIND_CHAT: begin
					res.deliver_chat = work_q.for_us;
					if (work_q.dst_me) begin
						res.send_ack   = 1'b1;
						res.ack_msg_id = work_q.key.msg_id;
						res.action     = ACT_FOR_ME;
					end else if (work_q.eligible) begin
						res.relay = work_q.can_relay;
						if (work_q.for_us) begin
							res.action = ACT_FOR_ME;
						end else begin
							res.action = work_q.can_relay ? ACT_RELAYED : ACT_EXPIRED;
						end
					end else begin
						res.action = work_q.for_us ? ACT_FOR_ME : ACT_RELAYED;
					end
				end
				default: begin
					res.action = ACT_DROP;
				end
			endcase
			if (res.relay) begin
				res.relay_ttl = work_q.relay_ttl;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			work_q <= q_data;
		end
		if (st_q == ST_LOOK) begin
			hit_q <= hit;
		end
		if (fire) begin
			res_q <= res;
		end
		if (cache_wr) begin
			seen_key_q[seen_ptr_q] <= work_q.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			seen_ptr_q  <= '0;
			for (int i = 0; i < SEEN_DEPTH; i++) begin
				seen_valid_q[i] <= 1'b0;
			end
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cache_wr) begin
				seen_valid_q[seen_ptr_q] <= 1'b1;
				seen_ptr_q <= (seen_ptr_q == SEEN_AW'(SEEN_DEPTH - 1)) ? '0 : seen_ptr_q + 1'b1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = res_q;

	a_look_then_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_LOOK) |=> (st_q == ST_DEC))
		else $error("lookup state not followed by decision state");

	a_cache_wr_in_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cache_wr |-> (st_q == ST_DEC) && !hit_q)
		else $error("cache written outside a new-packet decision");

	a_relay_ttl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.relay) |-> (res_q.relay_ttl != 8'd0))
		else $error("relay issued with exhausted ttl");

	a_learn_src: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.learn_source) |-> res_q.learn_neighbor)
		else $error("source learning without neighbor learning");

	a_resolve_ack: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.resolve_ack) |-> (res_q.action == ACT_ACK))
		else $error("ack resolve on a non-ack action");

endmodule
`default_nettype wire

@@ rtl/mesh_rx_dedup_forward_filter.sv @@
// Receive filter for mesh packet headers: drops short and own packets, removes
// repeats through a 16-entry ring cache of (type, source, id), and decides ack,
// relay, delivery, directory and route learning strobes for each header.
// Headers enter on the s_axis channel and one result item per header leaves on
// the m_axis channel. Registers are written through cfg_we, cfg_addr and
// cfg_wdata; the user must write them only while the block is idle, which the
// block itself does not enforce. An unknown index is ignored. A front part
// classifies each header against the registers and places it in a two-entry
// queue. The back part takes one item at a time: a lookup state does the
// parallel compare over all cache entries, then a decision state makes the
// decision and the cache update once the output register is free.
// A result waits in the output register while m_axis_tready is low; the queue
// keeps accepting until it holds two items, then s_axis_tready falls.
// Reset clears the cache valid bits and the write pointer and loads the default
// register values; the block is ready for input as soon as reset is released.
`default_nettype none
module mesh_rx_dedup_forward_filter
	import mrdf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFG_AW-1:0] cfg_addr,
	input  wire logic [7:0]        cfg_wdata,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	// too_short, msg_type, src_node, dst_node, prev_hop, next_hop, msg_id, ttl,
	// has_payload, first_payload, zero fill.
	input  wire logic [IN_W-1:0]   s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// action, send_ack, ack_msg_id, relay, relay_ttl, learn_neighbor,
	// learn_source, source_cost, deliver_chat, update_directory, resolve_ack,
	// acked_id, zero fill.
	output logic [OUT_W-1:0]       m_axis_tdata
);

	desc_t   front_desc;
	desc_t   q_data;
	logic    q_full;
	logic    q_empty;
	logic    q_pop;
	logic    push;
	result_t res;

	assign s_axis_tready = !q_full;
	assign push          = s_axis_tvalid && !q_full;

	mrdf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata),
		.in_valid (push),
		.in_data  (s_axis_tdata),
		.desc     (front_desc)
	);

	mrdf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(front_desc),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_data),
		.empty    (q_empty)
	);

	mrdf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_data),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_result(res)
	);

	assign m_axis_tdata = {6'd0, res.acked_id, res.resolve_ack, res.update_directory,
		res.deliver_chat, res.source_cost, res.learn_source, res.learn_neighbor,
		res.relay_ttl, res.relay, res.ack_msg_id, res.send_ack, res.action};

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;

	import mrdf_pkg::*;

	localparam logic [CFG_AW-1:0] REG_SPARE = 3'd7;
	localparam int ITEMS_PER_PHASE = 210;
	localparam int PHASES = 8;
	localparam int HOLD_AT_RESULT = 600;
	localparam int HOLD_CYCLES = 150;
	localparam int STALL_LIMIT = 2000;
	localparam int REPORT_CAP = 50;

	typedef struct packed {
		logic       too_short;
		logic [7:0] msg_type;
		logic [7:0] src_node;
		logic [7:0] dst_node;
		logic [7:0] prev_hop;
		logic [7:0] next_hop;
		logic [7:0] msg_id;
		logic [7:0] ttl;
		logic       has_payload;
		logic [7:0] first_payload;
	} header_t;

	typedef struct packed {
		logic [7:0] node_id;
		logic [7:0] bcast_id;
		logic [7:0] default_ttl;
		logic [7:0] t_presence;
		logic [7:0] t_route_adv;
		logic [7:0] t_ack;
		logic [7:0] t_chat;
	} filter_cfg_t;

	class verdict_board;
		filter_cfg_t cfg;
		logic        seen_valid [SEEN_DEPTH];
		logic [7:0]  seen_type [SEEN_DEPTH];
		logic [7:0]  seen_src [SEEN_DEPTH];
		logic [7:0]  seen_id [SEEN_DEPTH];
		int          seen_ptr;
		result_t     expected_verdicts [$];
		int          errors;

		function new();
			cfg = '{node_id: 8'h00, bcast_id: 8'hFF, default_ttl: 8'h07,
				t_presence: 8'h00, t_route_adv: 8'h01, t_ack: 8'h02, t_chat: 8'h03};
			for (int i = 0; i < SEEN_DEPTH; i++) begin
				seen_valid[i] = 1'b0;
				seen_type[i] = 8'h00;
				seen_src[i] = 8'h00;
				seen_id[i] = 8'h00;
			end
			seen_ptr = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_AW-1:0] idx, logic [7:0] v);
			case (idx)
				REG_NODE_ID: cfg.node_id = v;
				REG_BCAST_ID: cfg.bcast_id = v;
				REG_DEFAULT_TTL: cfg.default_ttl = v;
				REG_TYPE_PRESENCE: cfg.t_presence = v;
				REG_TYPE_ROUTE_ADV: cfg.t_route_adv = v;
				REG_TYPE_ACK: cfg.t_ack = v;
				REG_TYPE_CHAT: cfg.t_chat = v;
				default: ;
			endcase
		endfunction

		function bit seen_before(logic [7:0] t, logic [7:0] s, logic [7:0] id);
			for (int i = 0; i < SEEN_DEPTH; i++) begin
				if (seen_valid[i] && seen_type[i] == t && seen_src[i] == s && seen_id[i] == id)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		function void remember(logic [7:0] t, logic [7:0] s, logic [7:0] id);
			seen_valid[seen_ptr] = 1'b1;
			seen_type[seen_ptr] = t;
			seen_src[seen_ptr] = s;
			seen_id[seen_ptr] = id;
			seen_ptr = (seen_ptr + 1) % SEEN_DEPTH;
		endfunction

		function result_t decide(header_t h);
			result_t r;
			logic    eligible;
			logic    can_relay;
			logic    for_us;
			r = '0;
			eligible = (h.next_hop == cfg.node_id) || (h.next_hop == cfg.bcast_id);
			can_relay = eligible && (h.ttl > 8'd1);
			if (h.too_short || h.src_node == cfg.node_id) begin
				r.action = ACT_DROP;
			end else if (seen_before(h.msg_type, h.src_node, h.msg_id)) begin
				if (h.msg_type == cfg.t_chat && h.dst_node == cfg.node_id) begin
					r.send_ack = 1'b1;
					r.ack_msg_id = h.msg_id;
				end
				r.action = ACT_DROP;
			end else begin
				remember(h.msg_type, h.src_node, h.msg_id);
				if (h.prev_hop != cfg.node_id) begin
					r.learn_neighbor = 1'b1;
					if (h.src_node != h.prev_hop) begin
						r.learn_source = 1'b1;
						r.source_cost = cfg.default_ttl - h.ttl + 8'd1;
					end
				end
				if (h.msg_type == cfg.t_presence) begin
					r.update_directory = h.has_payload;
					r.relay = can_relay;
					r.action = ACT_PRESENCE;
				end else if (h.msg_type == cfg.t_route_adv) begin
					r.action = ACT_ROUTE_ADV;
				end else if (h.msg_type == cfg.t_ack) begin
					if (h.dst_node == cfg.node_id) begin
						if (h.has_payload) begin
							r.resolve_ack = 1'b1;
							r.acked_id = h.first_payload;
						end
						r.action = ACT_ACK;
					end else if (eligible) begin
						r.relay = can_relay;
						r.action = can_relay ? ACT_ACK : ACT_EXPIRED;
					end else begin
						r.action = ACT_ACK;
					end
				end else if (h.msg_type == cfg.t_chat) begin
					for_us = (h.dst_node == cfg.node_id) || (h.dst_node == cfg.bcast_id);
					r.deliver_chat = for_us;
					if (h.dst_node == cfg.node_id) begin
						r.send_ack = 1'b1;
						r.ack_msg_id = h.msg_id;
						r.action = ACT_FOR_ME;
					end else if (eligible) begin
						r.relay = can_relay;
						r.action = for_us ? ACT_FOR_ME : (can_relay ? ACT_RELAYED : ACT_EXPIRED);
					end else begin
						r.action = for_us ? ACT_FOR_ME : ACT_RELAYED;
					end
				end else begin
					r.action = ACT_DROP;
				end
				if (r.relay)
					r.relay_ttl = h.ttl - 8'd1;
			end
			return r;
		endfunction

		function void note_header(header_t h);
			expected_verdicts.push_back(decide(h));
		endfunction

		function int pending();
			return expected_verdicts.size();
		endfunction

		function void note_diff(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				if (errors < REPORT_CAP)
					$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_verdict(logic [OUT_W-1:0] d);
			result_t want;
			if (expected_verdicts.size() == 0) begin
				if (errors < REPORT_CAP)
					$display("%0t: result item %h with nothing expected, got %h",
						$time, {OUT_W{1'b0}}, d);
				errors++;
				return;
			end
			want = expected_verdicts.pop_front();
			note_diff("action", 8'(want.action), 8'(d[2:0]));
			note_diff("send_ack", 8'(want.send_ack), 8'(d[3]));
			note_diff("ack_msg_id", want.ack_msg_id, d[11:4]);
			note_diff("relay", 8'(want.relay), 8'(d[12]));
			note_diff("relay_ttl", want.relay_ttl, d[20:13]);
			note_diff("learn_neighbor", 8'(want.learn_neighbor), 8'(d[21]));
			note_diff("learn_source", 8'(want.learn_source), 8'(d[22]));
			note_diff("source_cost", want.source_cost, d[30:23]);
			note_diff("deliver_chat", 8'(want.deliver_chat), 8'(d[31]));
			note_diff("update_directory", 8'(want.update_directory), 8'(d[32]));
			note_diff("resolve_ack", 8'(want.resolve_ack), 8'(d[33]));
			note_diff("acked_id", want.acked_id, d[41:34]);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [CFG_AW-1:0] cfg_addr;
	logic [7:0]        cfg_wdata;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [IN_W-1:0]   s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [OUT_W-1:0]  m_axis_tdata;

	verdict_board board;
	bit           send_calm;
	bit           recv_calm;

	mesh_rx_dedup_forward_filter u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [IN_W-1:0] pack_header(header_t h);
		return {{(IN_W - 66){1'b0}}, h.first_payload, h.has_payload, h.ttl, h.msg_id,
			h.next_hop, h.prev_hop, h.dst_node, h.src_node, h.msg_type, h.too_short};
	endfunction

	function automatic header_t hdr(logic short_pkt, logic [7:0] mt, logic [7:0] src,
			logic [7:0] dst, logic [7:0] prev, logic [7:0] nxt, logic [7:0] id,
			logic [7:0] ttl, logic hp, logic [7:0] pl);
		header_t h;
		h.too_short = short_pkt;
		h.msg_type = mt;
		h.src_node = src;
		h.dst_node = dst;
		h.prev_hop = prev;
		h.next_hop = nxt;
		h.msg_id = id;
		h.ttl = ttl;
		h.has_payload = hp;
		h.first_payload = pl;
		return h;
	endfunction

	function automatic logic [7:0] pick_addr();
		case ($urandom_range(0, 7))
			0, 1: return board.cfg.node_id;
			2: return board.cfg.bcast_id;
			3, 4: return 8'hA0 + 8'($urandom_range(0, 3));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic header_t make_header();
		header_t h;
		h = header_t'({$urandom, $urandom, $urandom});
		if ($urandom_range(0, 3) == 0)
			return h;
		// Well-formed traffic: small pools of types, sources and ids so that
		// repeats hit the cache and addresses often match this node.
		h.too_short = ($urandom_range(0, 15) == 0);
		case ($urandom_range(0, 9))
			0, 1: h.msg_type = board.cfg.t_presence;
			2: h.msg_type = board.cfg.t_route_adv;
			3, 4: h.msg_type = board.cfg.t_ack;
			5, 6, 7: h.msg_type = board.cfg.t_chat;
			default: h.msg_type = 8'($urandom);
		endcase
		case ($urandom_range(0, 15))
			0: h.src_node = board.cfg.node_id;
			1: h.src_node = 8'($urandom);
			default: h.src_node = 8'hA0 + 8'($urandom_range(0, 3));
		endcase
		h.dst_node = pick_addr();
		h.prev_hop = ($urandom_range(0, 3) == 0) ? h.src_node : pick_addr();
		h.next_hop = pick_addr();
		h.msg_id = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
		case ($urandom_range(0, 5))
			0: h.ttl = 8'd0;
			1: h.ttl = 8'd1;
			2: h.ttl = 8'd2;
			3: h.ttl = board.cfg.default_ttl;
			default: h.ttl = 8'($urandom);
		endcase
		return h;
	endfunction

	function automatic filter_cfg_t phase_cfg(int p);
		filter_cfg_t c;
		case (p)
			1: c = '{node_id: 8'hFF, bcast_id: 8'h00, default_ttl: 8'hFF, t_presence: 8'hFF,
				t_route_adv: 8'h00, t_ack: 8'h80, t_chat: 8'h7F};
			2: c = '{node_id: 8'h00, bcast_id: 8'h00, default_ttl: 8'h01, t_presence: 8'h55,
				t_route_adv: 8'h55, t_ack: 8'h55, t_chat: 8'h55};
			3: c = '{node_id: 8'h5A, bcast_id: 8'hFF, default_ttl: 8'h07, t_presence: 8'h10,
				t_route_adv: 8'h11, t_ack: 8'h11, t_chat: 8'h11};
			4: c = '{node_id: 8'h80, bcast_id: 8'h7F, default_ttl: 8'h80, t_presence: 8'h03,
				t_route_adv: 8'h03, t_ack: 8'h02, t_chat: 8'h02};
			default: begin
				c.node_id = 8'($urandom);
				c.bcast_id = ($urandom_range(0, 1) == 0) ? 8'hFF : 8'($urandom);
				c.default_ttl = 8'($urandom_range(1, 255));
				c.t_presence = 8'($urandom_range(0, 7));
				c.t_route_adv = 8'($urandom_range(0, 7));
				c.t_ack = 8'($urandom_range(0, 7));
				c.t_chat = 8'($urandom_range(0, 7));
			end
		endcase
		return c;
	endfunction

	task automatic write_reg(logic [CFG_AW-1:0] idx, logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		board.set_reg(idx, v);
	endtask

	task automatic set_config(filter_cfg_t c);
		write_reg(REG_NODE_ID, c.node_id);
		write_reg(REG_BCAST_ID, c.bcast_id);
		write_reg(REG_DEFAULT_TTL, c.default_ttl);
		write_reg(REG_TYPE_PRESENCE, c.t_presence);
		write_reg(REG_TYPE_ROUTE_ADV, c.t_route_adv);
		write_reg(REG_TYPE_ACK, c.t_ack);
		write_reg(REG_TYPE_CHAT, c.t_chat);
		write_reg(REG_SPARE, 8'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_header(header_t h);
		int gap;
		gap = send_calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= pack_header(h);
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		board.note_header(h);
		if ($urandom_range(0, 49) == 0)
			send_calm = !send_calm;
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic run_directed();
		// Reset register values: node 0, broadcast 255, default ttl 7, types 0 to 3.
		send_header(hdr(1, 3, 5, 0, 5, 0, 1, 7, 1, 8'h11));
		send_header(hdr(0, 3, 0, 9, 4, 0, 1, 7, 1, 8'h11));
		send_header(hdr(0, 3, 5, 0, 5, 0, 1, 7, 1, 8'h22));
		send_header(hdr(0, 3, 5, 0, 5, 0, 1, 7, 1, 8'h22));
		send_header(hdr(0, 0, 6, 255, 7, 255, 2, 3, 1, 8'h33));
		send_header(hdr(0, 0, 6, 255, 7, 255, 2, 3, 1, 8'h33));
		send_header(hdr(0, 0, 9, 255, 9, 255, 3, 1, 0, 8'h00));
		send_header(hdr(0, 1, 9, 255, 4, 255, 3, 5, 1, 8'h44));
		send_header(hdr(0, 2, 12, 0, 12, 255, 4, 6, 1, 8'h5C));
		send_header(hdr(0, 2, 13, 0, 4, 0, 4, 6, 0, 8'h77));
		send_header(hdr(0, 2, 14, 20, 4, 0, 5, 4, 1, 8'h01));
		send_header(hdr(0, 2, 15, 20, 4, 255, 5, 1, 1, 8'h02));
		send_header(hdr(0, 2, 16, 20, 4, 30, 5, 9, 0, 8'h00));
		send_header(hdr(0, 3, 17, 255, 4, 255, 6, 5, 1, 8'h03));
		send_header(hdr(0, 3, 18, 21, 4, 0, 6, 0, 1, 8'h04));
		send_header(hdr(0, 3, 19, 21, 4, 30, 6, 3, 1, 8'h00));
		send_header(hdr(0, 3, 20, 21, 4, 0, 6, 255, 1, 8'h00));
		send_header(hdr(0, 8'hFF, 22, 0, 4, 0, 7, 2, 1, 8'h00));
		send_header(hdr(0, 3, 23, 0, 0, 0, 8, 7, 1, 8'h00));
		send_header(hdr(0, 0, 24, 255, 24, 255, 9, 7, 0, 8'h00));
		send_header(hdr(0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 8'hFF));
		send_header(hdr(0, 0, 1, 0, 0, 0, 0, 0, 0, 8'h00));
		send_header(hdr(0, 2, 5, 0, 5, 0, 1, 7, 1, 8'h01));
		send_header(hdr(1, 3, 5, 0, 5, 0, 1, 7, 1, 8'h00));
	endtask

	initial begin
		int taken;
		int gap;
		m_axis_tready = 1'b0;
		taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = recv_calm ? 0 : $urandom_range(0, 5);
			// One long hold-off fills the input queue and stalls the sender.
			if (taken == HOLD_AT_RESULT)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
			board.check_verdict(m_axis_tdata);
			taken++;
			if ($urandom_range(0, 49) == 0)
				recv_calm = !recv_calm;
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					cfg_we || !arst_n)
				idle = 0;
			else
				idle++;
		end
		$display("** mesh_rx_dedup_forward_filter: FAILED **");
		$finish;
	end

	initial begin
		board = new();
		send_calm = 1'b0;
		recv_calm = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				drain();
				set_config(phase_cfg(p));
			end
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_header(make_header());
		end
		s_axis_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("** mesh_rx_dedup_forward_filter: PASSED **");
		else
			$display("** mesh_rx_dedup_forward_filter: FAILED **");
		$finish;
	end

endmodule
